/* rtl/core/gcm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// gcm_pkg
// shared types, constants and root table function for the gamma colour map
// ============================================================================
package gcm_pkg;

   localparam int SAMPLE_BITS   = 24;
   localparam int FRACTION_DEF  = 16;
   localparam int FS_W          = 23;
   localparam int IG_W          = 16;
   localparam int OFS_W         = 24;
   localparam int LVL_W         = 8;
   localparam int Y_W           = 31;   // q1.30
   localparam int Q_SHIFT       = 30;
   localparam int LOG_STEPS     = 16;
   localparam int EXP_STEPS     = 16;
   localparam int G_SHIFT       = 12;   // inv_gamma is q4.12
   localparam int ADDR_W        = 4;

   localparam logic [1:0] MODE_COLOUR = 2'd0;
   localparam logic [1:0] MODE_MONO   = 2'd1;
   localparam logic [1:0] MODE_MIXED  = 2'd2;
   localparam logic [1:0] MODE_BLACK  = 2'd3;

   localparam logic [1:0] KIND_DIEL   = 2'd0;
   localparam logic [1:0] KIND_ZERO   = 2'd1;
   localparam logic [1:0] KIND_POS    = 2'd2;
   localparam logic [1:0] KIND_NEG    = 2'd3;

   localparam logic [1:0] REG_MODE    = 2'd0;
   localparam logic [1:0] REG_FS      = 2'd1;
   localparam logic [1:0] REG_IG      = 2'd2;

   localparam logic [FS_W-1:0] FS_RESET = 23'h7FFFFF;
   localparam logic [IG_W-1:0] IG_RESET = 16'd4096;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic [1:0]                    cell_kind;
      logic [OFS_W-1:0]              pixel_offset;
   } req_type;

   typedef struct packed {
      logic [LVL_W-1:0] blue_level;
      logic [LVL_W-1:0] green_level;
      logic [LVL_W-1:0] red_level;
      logic [OFS_W-1:0] out_offset;
   } rsp_type;

   // per-pixel flags that ride along the pipeline
   typedef struct packed {
      logic             neg;
      logic             sat;
      logic             black;
      logic             zero;
      logic [1:0]       kind;
      logic [OFS_W-1:0] offset;
   } side_type;

   function automatic logic [63:0] gcm_isqrt(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitv;
      logic [63:0] rem;
      res  = 64'd0;
      bitv = 64'd1 << 60;
      rem  = v;
      for (int i = 0; i < 31; i++) begin
         if (rem >= res + bitv) begin
            rem = rem - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // q0.30 root constant c_k = 2^(-2^-k), elaboration only
   function automatic logic [63:0] gcm_root(input int k);
      logic [63:0] c;
      c = 64'd1 << 29;
      for (int i = 1; i <= k; i++) begin
         c = gcm_isqrt(c << 30);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

/* rtl/core/gcm_div_stage.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// gcm_div_stage
// one restoring step of the magnitude / full scale ratio
// ============================================================================
module gcm_div_stage #(
   parameter int FB = gcm_pkg::FRACTION_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic [gcm_pkg::FS_W-1:0] full_scale,
   input  wire logic                     in_valid,
   input  wire gcm_pkg::side_type        in_side,
   input  wire logic [gcm_pkg::FS_W-1:0] in_rem,
   input  wire logic [FB-1:0]            in_quo,
   output logic                          out_valid_ff,
   output gcm_pkg::side_type             out_side_ff,
   output logic [gcm_pkg::FS_W-1:0]      out_rem_ff,
   output logic [FB-1:0]                 out_quo_ff
);
   import gcm_pkg::*;

   logic [FS_W:0]   shifted;
   logic            take;
   logic [FS_W:0]   diff;
   logic [FS_W-1:0] rem_in;
   logic [FB-1:0]   quo_in;

   always_comb begin
      shifted = {in_rem, 1'b0};
      take    = shifted >= {1'b0, full_scale};
      diff    = shifted - {1'b0, full_scale};
      rem_in  = take ? diff[FS_W-1:0] : shifted[FS_W-1:0];
      quo_in  = {in_quo[FB-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= in_valid;
      end
      out_side_ff <= in_side;
      out_rem_ff  <= rem_in;
      out_quo_ff  <= quo_in;
   end

endmodule
`default_nettype wire

/* rtl/core/gcm_sq_stage.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// gcm_sq_stage
// one squaring step of the log2 fraction, emits one bit
// ============================================================================
module gcm_sq_stage #(
   parameter int AUX_W = 21
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   input  wire gcm_pkg::side_type       in_side,
   input  wire logic [gcm_pkg::Y_W-1:0] in_y,
   input  wire logic [gcm_pkg::LOG_STEPS-1:0] in_f,
   input  wire logic [AUX_W-1:0]        in_aux,
   output logic                         out_valid_ff,
   output gcm_pkg::side_type            out_side_ff,
   output logic [gcm_pkg::Y_W-1:0]      out_y_ff,
   output logic [gcm_pkg::LOG_STEPS-1:0] out_f_ff,
   output logic [AUX_W-1:0]             out_aux_ff
);
   import gcm_pkg::*;

   logic [2*Y_W-1:0]     sq;
   logic [Y_W:0]         sq_top;
   logic [Y_W-1:0]       y_in;
   logic [LOG_STEPS-1:0] f_in;

   always_comb begin
      sq     = {{Y_W{1'b0}}, in_y} * {{Y_W{1'b0}}, in_y};
      sq_top = sq[Q_SHIFT+Y_W:Q_SHIFT];
      y_in   = sq_top[Y_W] ? sq_top[Y_W:1] : sq_top[Y_W-1:0];
      f_in   = {in_f[LOG_STEPS-2:0], sq_top[Y_W]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= in_valid;
      end
      out_side_ff <= in_side;
      out_y_ff    <= y_in;
      out_f_ff    <= f_in;
      out_aux_ff  <= in_aux;
   end

endmodule
`default_nettype wire

/* rtl/core/gcm_exp_stage.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// gcm_exp_stage
// one conditional root multiply of the exp2 fraction
// ============================================================================
module gcm_exp_stage #(
   parameter int K     = 1,
   parameter int AUX_W = 9
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   input  wire gcm_pkg::side_type       in_side,
   input  wire logic [gcm_pkg::Y_W-1:0] in_m,
   input  wire logic [gcm_pkg::EXP_STEPS-1:0] in_g,
   input  wire logic [AUX_W-1:0]        in_aux,
   output logic                         out_valid_ff,
   output gcm_pkg::side_type            out_side_ff,
   output logic [gcm_pkg::Y_W-1:0]      out_m_ff,
   output logic [gcm_pkg::EXP_STEPS-1:0] out_g_ff,
   output logic [AUX_W-1:0]             out_aux_ff
);
   import gcm_pkg::*;

   localparam logic [63:0]    ROOT_FULL = gcm_root(K);
   localparam logic [Y_W-1:0] ROOT      = ROOT_FULL[Y_W-1:0];

   logic [2*Y_W-1:0] prod;
   logic [Y_W-1:0]   m_in;

   always_comb begin
      prod = {{Y_W{1'b0}}, in_m} * {{Y_W{1'b0}}, ROOT};
      m_in = in_g[EXP_STEPS-K] ? prod[Q_SHIFT+Y_W-1:Q_SHIFT] : in_m;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= in_valid;
      end
      out_side_ff <= in_side;
      out_m_ff    <= m_in;
      out_g_ff    <= in_g;
      out_aux_ff  <= in_aux;
   end

endmodule
`default_nettype wire

/* rtl/core/gamma_colour_map_pixel_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// gamma_colour_map_pixel_core
// maps a signed field sample to a gamma corrected bgr pixel
// ============================================================================
//
//  channel  | ports                          | handshake
//  ---------+--------------------------------+------------------------------
//  request  | start, busy, req_payload       | taken when start && !busy
//  response | rsp_strobe, rsp_payload        | one-cycle strobe, no backpressure
//  control  | csr_psel .. csr_pready         | apb write on access phase
//
//  one pixel per cycle, fully pipelined; busy is never raised
//  from start to rsp_strobe a pixel passes the entry register, the
//  bit-per-stage divider, the normalize register, the 16 squaring stages,
//  the exponent register, the 16 root-multiply stages and the shift and output registers
//  synchronous reset clears the valid chain; config returns to defaults
//  the receiver cannot stall, so nothing in the pipe ever holds
//
module gamma_colour_map_pixel_core #(
   parameter int FRACTION_BITS = gcm_pkg::FRACTION_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // request
   input  wire logic                       start,
   output logic                            busy,
   input  wire gcm_pkg::req_type           req_payload,
   // response
   output logic                            rsp_strobe,
   output gcm_pkg::rsp_type                rsp_payload,
   // control registers
   input  wire logic                       csr_psel,
   input  wire logic                       csr_penable,
   input  wire logic                       csr_pwrite,
   input  wire logic [gcm_pkg::ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]                csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import gcm_pkg::*;

   localparam int FB    = FRACTION_BITS;
   localparam int PW    = 5;                        // shift amounts up to 30
   localparam int LW    = 16 + $clog2(FB + 1);      // -log2 in q.16
   localparam int EW    = LW + 16 - G_SHIFT;        // scaled exponent
   localparam int NW    = EW - 16;                  // integer part of exponent
   localparam int SB    = SAMPLE_BITS;

   // ---------------------------------------------------------------------
   // control registers; the user must write them only while the pipe is empty, the block does not enforce it
   // ---------------------------------------------------------------------
   logic [1:0]      mode_ff;
   logic [FS_W-1:0] fs_ff;
   logic [IG_W-1:0] ig_ff;
   logic            wr_en;

   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign busy       = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_COLOUR;
         fs_ff   <= FS_RESET;
         ig_ff   <= IG_RESET;
      end else if (wr_en) begin
         case (csr_paddr[3:2])
            REG_MODE: mode_ff <= csr_pwdata[1:0];
            REG_FS:   fs_ff   <= csr_pwdata[FS_W-1:0];
            REG_IG:   ig_ff   <= csr_pwdata[IG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_MODE: csr_prdata = {30'd0, mode_ff};
         REG_FS:   csr_prdata = {{(32-FS_W){1'b0}}, fs_ff};
         REG_IG:   csr_prdata = {{(32-IG_W){1'b0}}, ig_ff};
         default:  csr_prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------------
   // entry stage: magnitude and saturation flags
   // ---------------------------------------------------------------------
   logic          neg;
   logic [SB-1:0] mag;
   logic [SB-1:0] fs_ext;
   side_type      side_in;

   always_comb begin
      neg            = req_payload.sample[SB-1];
      mag            = neg ? SB'(-req_payload.sample) : SB'(req_payload.sample);
      fs_ext         = SB'(fs_ff);
      side_in.neg    = neg;
      side_in.sat    = (mag >= fs_ext) || (ig_ff == '0);
      side_in.black  = !neg && (mag > fs_ext);
      side_in.zero   = 1'b0;
      side_in.kind   = req_payload.cell_kind;
      side_in.offset = req_payload.pixel_offset;
   end

   logic            div_valid [0:FB];
   side_type        div_side  [0:FB];
   logic [FS_W-1:0] div_rem   [0:FB];
   logic [FB-1:0]   div_quo   [0:FB];

   always_ff @(posedge clock) begin
      if (reset) begin
         div_valid[0] <= 1'b0;
      end else begin
         div_valid[0] <= start;
      end
      div_side[0] <= side_in;
      div_rem[0]  <= mag[FS_W-1:0];
      div_quo[0]  <= '0;
   end

   // ratio: one quotient bit per stage
   for (genvar i = 0; i < FB; i++) begin : g_div
      gcm_div_stage #(.FB(FB)) u_div (
         .clock        (clock),
         .reset        (reset),
         .full_scale   (fs_ff),
         .in_valid     (div_valid[i]),
         .in_side      (div_side[i]),
         .in_rem       (div_rem[i]),
         .in_quo       (div_quo[i]),
         .out_valid_ff (div_valid[i+1]),
         .out_side_ff  (div_side[i+1]),
         .out_rem_ff   (div_rem[i+1]),
         .out_quo_ff   (div_quo[i+1])
      );
   end

   // ---------------------------------------------------------------------
   // normalize: top bit search, q1.30 mantissa, integer log part
   // ---------------------------------------------------------------------
   logic [FB-1:0] ratio;
   logic [PW-1:0] top;
   logic [Y_W-1:0] y0;
   logic [LW-1:0]  lhi;
   side_type       norm_side;

   always_comb begin
      ratio = div_quo[FB];
      top   = '0;
      for (int b = 0; b < FB; b++) begin
         if (ratio[b]) top = PW'(b);
      end
      y0             = Y_W'(ratio) << (PW'(Q_SHIFT) - top);
      lhi            = (LW'(FB) - LW'(top)) << 16;
      norm_side      = div_side[FB];
      norm_side.zero = (ratio == '0);
   end

   logic                 sq_valid [0:LOG_STEPS];
   side_type             sq_side  [0:LOG_STEPS];
   logic [Y_W-1:0]       sq_y     [0:LOG_STEPS];
   logic [LOG_STEPS-1:0] sq_f     [0:LOG_STEPS];
   logic [LW-1:0]        sq_aux   [0:LOG_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid[0] <= 1'b0;
      end else begin
         sq_valid[0] <= div_valid[FB];
      end
      sq_side[0] <= norm_side;
      sq_y[0]    <= y0;
      sq_f[0]    <= '0;
      sq_aux[0]  <= lhi;
   end

   // fractional log2: one bit per squaring
   for (genvar i = 0; i < LOG_STEPS; i++) begin : g_log
      gcm_sq_stage #(.AUX_W(LW)) u_sq (
         .clock        (clock),
         .reset        (reset),
         .in_valid     (sq_valid[i]),
         .in_side      (sq_side[i]),
         .in_y         (sq_y[i]),
         .in_f         (sq_f[i]),
         .in_aux       (sq_aux[i]),
         .out_valid_ff (sq_valid[i+1]),
         .out_side_ff  (sq_side[i+1]),
         .out_y_ff     (sq_y[i+1]),
         .out_f_ff     (sq_f[i+1]),
         .out_aux_ff   (sq_aux[i+1])
      );
   end

   // ---------------------------------------------------------------------
   // exponent: -log2(ratio) times inv_gamma
   // ---------------------------------------------------------------------
   logic [LW-1:0]    lval;
   logic [LW+15:0]   eprod;
   logic [EW-1:0]    eval_in;

   always_comb begin
      lval    = sq_aux[LOG_STEPS] - LW'(sq_f[LOG_STEPS]);
      eprod   = (LW+16)'(lval) * (LW+16)'(ig_ff);
      eval_in = eprod[LW+15:G_SHIFT];
   end

   logic                 ex_valid [0:EXP_STEPS];
   side_type             ex_side  [0:EXP_STEPS];
   logic [Y_W-1:0]       ex_m     [0:EXP_STEPS];
   logic [EXP_STEPS-1:0] ex_g     [0:EXP_STEPS];
   logic [NW-1:0]        ex_n     [0:EXP_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid[0] <= 1'b0;
      end else begin
         ex_valid[0] <= sq_valid[LOG_STEPS];
      end
      ex_side[0] <= sq_side[LOG_STEPS];
      ex_m[0]    <= Y_W'(1) << Q_SHIFT;
      ex_g[0]    <= eval_in[15:0];
      ex_n[0]    <= eval_in[EW-1:16];
   end

   // fractional exp2: one root multiply per exponent bit
   for (genvar i = 0; i < EXP_STEPS; i++) begin : g_exp
      gcm_exp_stage #(.K(i + 1), .AUX_W(NW)) u_exp (
         .clock        (clock),
         .reset        (reset),
         .in_valid     (ex_valid[i]),
         .in_side      (ex_side[i]),
         .in_m         (ex_m[i]),
         .in_g         (ex_g[i]),
         .in_aux       (ex_n[i]),
         .out_valid_ff (ex_valid[i+1]),
         .out_side_ff  (ex_side[i+1]),
         .out_m_ff     (ex_m[i+1]),
         .out_g_ff     (ex_g[i+1]),
         .out_aux_ff   (ex_n[i+1])
      );
   end

   // ---------------------------------------------------------------------
   // integer exponent as a right shift
   // ---------------------------------------------------------------------
   logic           shv_valid_ff;
   side_type       shv_side_ff;
   logic [Y_W-1:0] shv_ff;
   logic [Y_W-1:0] shv_in;

   assign shv_in = (ex_n[EXP_STEPS] > NW'(Q_SHIFT)) ? '0 : (ex_m[EXP_STEPS] >> ex_n[EXP_STEPS]);

   always_ff @(posedge clock) begin
      if (reset) begin
         shv_valid_ff <= 1'b0;
      end else begin
         shv_valid_ff <= ex_valid[EXP_STEPS];
      end
      shv_side_ff <= ex_side[EXP_STEPS];
      shv_ff      <= shv_in;
   end

   // ---------------------------------------------------------------------
   // level scale and mode select
   // ---------------------------------------------------------------------
   logic [Y_W+LVL_W-1:0] lprod;
   logic [LVL_W-1:0]     lvl;
   rsp_type              rsp_in;

   always_comb begin
      lprod = (Y_W+LVL_W)'(shv_ff) * (Y_W+LVL_W)'(8'd255);
      if (shv_side_ff.sat) begin
         lvl = 8'd255;
      end else if (shv_side_ff.zero) begin
         lvl = '0;
      end else begin
         lvl = lprod[Q_SHIFT+LVL_W-1:Q_SHIFT];
      end

      rsp_in            = '0;
      rsp_in.out_offset = shv_side_ff.offset;
      case (mode_ff)
         MODE_COLOUR: begin
            if (shv_side_ff.neg) rsp_in.blue_level = lvl;
            else                 rsp_in.red_level  = lvl;
         end
         MODE_MONO: begin
            if (!shv_side_ff.black) begin
               rsp_in.blue_level  = lvl;
               rsp_in.green_level = lvl;
               rsp_in.red_level   = lvl;
            end
         end
         MODE_MIXED: begin
            case (shv_side_ff.kind)
               KIND_ZERO: rsp_in.green_level = 8'd255;
               KIND_POS:  rsp_in.red_level   = 8'd255;
               KIND_NEG:  rsp_in.blue_level  = 8'd255;
               default: begin
                  rsp_in.blue_level  = lvl;
                  rsp_in.green_level = lvl;
                  rsp_in.red_level   = lvl;
               end
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= shv_valid_ff;
      end
      rsp_payload <= rsp_in;
   end

endmodule
`default_nettype wire

/* rtl/core/gcm_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// gcm_checker
// port-level checks on the gamma colour map core
// ============================================================================
module gcm_checker #(
   parameter int LATENCY = gcm_pkg::FRACTION_DEF + 37
) (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       start,
   input wire logic                       busy,
   input wire gcm_pkg::req_type           req_payload,
   input wire logic                       rsp_strobe,
   input wire gcm_pkg::rsp_type           rsp_payload,
   input wire logic                       csr_pready
);
   import gcm_pkg::*;

   a_never_busy: assert property (@(posedge clock) !busy)
      else $error("busy raised");

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("response after reset");

   a_fixed_latency: assert property (@(posedge clock)
      rsp_strobe |-> $past(start, LATENCY))
      else $error("response without matching request");

   a_offset_kept: assert property (@(posedge clock)
      rsp_strobe |-> rsp_payload.out_offset == $past(req_payload.pixel_offset, LATENCY))
      else $error("pixel offset corrupted");

   a_ready: assert property (@(posedge clock) csr_pready)
      else $error("pready low");

endmodule

bind gamma_colour_map_pixel_core gcm_checker #(.LATENCY(FRACTION_BITS + 37)) u_gcm_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_payload (req_payload),
   .rsp_strobe  (rsp_strobe),
   .rsp_payload (rsp_payload),
   .csr_pready  (csr_pready)
);
`default_nettype wire
